FILE: rtl/mmce_pkg.sv
`timescale 1ns / 1ps
package mmce_pkg;

   typedef enum logic [3:0] {
      MODE_NONE    = 4'd0,
      MODE_XOR     = 4'd1,
      MODE_SUM8    = 4'd2,
      MODE_SUM16   = 4'd3,
      MODE_CRC8    = 4'd4,
      MODE_CRC8_8D = 4'd5,
      MODE_ARC     = 4'd6,
      MODE_CCITT   = 4'd7,
      MODE_MODBUS  = 4'd8,
      MODE_XMODEM  = 4'd9,
      MODE_CRC32   = 4'd10,
      MODE_CRC32C  = 4'd11
   } mode_type;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_CHECK_MODE = 1'b0;

   localparam logic [7:0]  POLY_CRC8    = 8'h07;
   localparam logic [7:0]  POLY_CRC8_8D = 8'h8D;
   localparam logic [15:0] POLY_A001    = 16'hA001;
   localparam logic [15:0] POLY_1021    = 16'h1021;
   localparam logic [31:0] POLY_CRC32   = 32'hEDB88320;
   localparam logic [31:0] POLY_CRC32C  = 32'h82F63B78;

   localparam logic [2:0] SIZE_NONE = 3'd0;
   localparam logic [2:0] SIZE_1    = 3'd1;
   localparam logic [2:0] SIZE_2    = 3'd2;
   localparam logic [2:0] SIZE_4    = 3'd4;

   function automatic logic [31:0] init_for(mode_type mode);
      logic [31:0] v;
      case (mode)
         MODE_CCITT, MODE_MODBUS: v = 32'h0000_FFFF;
         MODE_CRC32, MODE_CRC32C: v = 32'hFFFF_FFFF;
         default:                 v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] size_for(mode_type mode);
      logic [2:0] s;
      case (mode)
         MODE_XOR, MODE_SUM8, MODE_CRC8, MODE_CRC8_8D: s = SIZE_1;
         MODE_SUM16, MODE_ARC, MODE_CCITT, MODE_MODBUS, MODE_XMODEM: s = SIZE_2;
         MODE_CRC32, MODE_CRC32C: s = SIZE_4;
         default: s = SIZE_NONE;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/mmce_req_if.sv
`timescale 1ns / 1ps
interface mmce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/mmce_rsp_if.sv
`timescale 1ns / 1ps
interface mmce_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] check_value;
   logic [2:0]  check_size;

   modport source (output valid, output check_value, output check_size, input ready);
   modport sink (input valid, input check_value, input check_size, output ready);
endinterface

FILE: rtl/mmce_fold.sv
`timescale 1ns / 1ps
module mmce_fold (
   input  mmce_pkg::mode_type mode,
   input  logic [31:0]        cur_value,
   input  logic [7:0]         data_byte,
   output logic [31:0]        next_value
);
   import mmce_pkg::*;

   // msb-first crc, byte enters at the top
   function automatic logic [7:0] crc8_msb(logic [7:0] v, logic [7:0] b, logic [7:0] poly);
      logic [7:0] c;
      c = v ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_msb(logic [15:0] v, logic [7:0] b,
                                             logic [15:0] poly);
      logic [15:0] c;
      c = v ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

   // reflected crc, byte enters at the bottom
   function automatic logic [15:0] crc16_lsb(logic [15:0] v, logic [7:0] b,
                                             logic [15:0] poly);
      logic [15:0] c;
      c = v ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc32_lsb(logic [31:0] v, logic [7:0] b,
                                             logic [31:0] poly);
      logic [31:0] c;
      c = v ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   logic [7:0]  sum8;
   logic [15:0] sum16;

   assign sum8  = cur_value[7:0] + data_byte;
   assign sum16 = cur_value[15:0] + {8'h00, data_byte};

   always_comb begin
      case (mode)
         MODE_XOR:     next_value = {24'h0, cur_value[7:0] ^ data_byte};
         MODE_SUM8:    next_value = {24'h0, sum8};
         MODE_SUM16:   next_value = {16'h0, sum16};
         MODE_CRC8:    next_value = {24'h0, crc8_msb(cur_value[7:0], data_byte, POLY_CRC8)};
         MODE_CRC8_8D: begin
            next_value = {24'h0, crc8_msb(cur_value[7:0], data_byte, POLY_CRC8_8D)};
         end
         MODE_ARC, MODE_MODBUS: begin
            next_value = {16'h0, crc16_lsb(cur_value[15:0], data_byte, POLY_A001)};
         end
         MODE_CCITT, MODE_XMODEM: begin
            next_value = {16'h0, crc16_msb(cur_value[15:0], data_byte, POLY_1021)};
         end
         MODE_CRC32:   next_value = crc32_lsb(cur_value, data_byte, POLY_CRC32);
         MODE_CRC32C:  next_value = crc32_lsb(cur_value, data_byte, POLY_CRC32C);
         default:      next_value = 32'h0;
      endcase
   end

endmodule

FILE: rtl/multi_mode_checksum_engine_unit.sv
`timescale 1ns / 1ps
// a message's result shows on rsp in the cycle after its last item is taken
// one item per cycle unless a result stalls; fold is one unrolled eight-step update
// the result register frees up in the same cycle its result is taken
// reset (synchronous, active high) sets mode none, running value 0, no result pending
module multi_mode_checksum_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   mmce_req_if.sink                            req_if,
   mmce_rsp_if.source                          rsp_if,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mmce_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mmce_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mmce_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mmce_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [31:0] running_ff, running_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  size_ff, size_in;

   logic [31:0] folded;
   logic        req_take;
   logic        csr_wr;
   logic        mode_is_crc32;

   mmce_fold u_fold (
      .mode       (mode_ff),
      .cur_value  (running_ff),
      .data_byte  (req_if.data_byte),
      .next_value (folded)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_wr       = csr_psel && csr_penable && csr_pwrite &&
                         (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_CHECK_MODE);
   assign mode_is_crc32 = (mode_ff == MODE_CRC32) || (mode_ff == MODE_CRC32C);

   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-4){1'b0}}, mode_ff};

   always_comb begin
      mode_in      = mode_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      value_in     = value_ff;
      size_in      = size_ff;
      if (csr_wr) begin
         mode_in    = mode_type'(csr_pwdata[3:0]);
         running_in = init_for(mode_type'(csr_pwdata[3:0]));
      end else if (req_take) begin
         if (req_if.last_byte) begin
            running_in   = init_for(mode_ff);
            rsp_valid_in = 1'b1;
            value_in     = mode_is_crc32 ? ~folded : folded;
            size_in      = size_for(mode_ff);
         end else begin
            running_in = folded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         running_ff   <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      size_ff  <= size_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.check_value = value_ff;
   assign rsp_if.check_size  = size_ff;

endmodule

FILE: rtl/mmce_checker.sv
`timescale 1ns / 1ps
module mmce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] check_value,
   input logic [2:0]  check_size
);
   import mmce_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(check_value) && $stable(check_size))
      else $error("stalled result changed");

   a_ready_when_empty: assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_size_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (check_size == SIZE_NONE) || (check_size == SIZE_1) ||
                    (check_size == SIZE_2) || (check_size == SIZE_4))
      else $error("bad check size");

   a_value_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((check_size == SIZE_NONE) && (check_value == 32'h0)) ||
                    ((check_size == SIZE_1) && (check_value[31:8] == 24'h0)) ||
                    ((check_size == SIZE_2) && (check_value[31:16] == 16'h0)) ||
                    (check_size == SIZE_4))
      else $error("check value wider than its size");

endmodule

bind multi_mode_checksum_engine_unit mmce_checker u_mmce_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .check_value (rsp_if.check_value),
   .check_size  (rsp_if.check_size)
);
